>>> src/hrhp_pkg.sv
// hrhp_pkg: item types, result codes and match text for the response header parser
// no dependencies; used by hrhp_core and http_response_header_parser
`default_nettype none

package hrhp_pkg;

  // one input item: a raw response byte and the start-of-response mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } byte_item_t;

  // one result item
  typedef struct packed {
    logic [1:0] parse_state;
    logic [9:0] status_code;
    logic       body_valid;
    logic [7:0] body_byte;
  } result_item_t;

  // parse_state codes
  localparam logic [1:0] PS_MORE_DATA = 2'd0;
  localparam logic [1:0] PS_INVALID   = 2'd1;
  localparam logic [1:0] PS_COMPLETE  = 2'd2;

  // status line layout
  localparam logic [3:0] POS_VERSION_DIGIT = 4'd7;
  localparam logic [3:0] POS_STATUS_FIRST  = 4'd9;
  localparam logic [3:0] POS_STATUS_LAST   = 4'd11;
  localparam logic [3:0] POS_HEADER_DONE   = 4'd12;

  localparam logic signed [15:0] STATUS_MIN = 16'sd100;
  localparam logic signed [15:0] STATUS_MAX = 16'sd599;

  // declared length encodings
  localparam logic [31:0] LENGTH_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] LENGTH_MAX  = 32'h7FFF_FFFF;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // length of "Content-Length:"
  localparam logic [3:0] PAT_LEN = 4'd15;

  // "HTTP/1." by position
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2F;
      3'd5: c = 8'h31;
      3'd6: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Content-Length:" by position
  function automatic logic [7:0] length_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = 8'h43;
      4'd1:  c = 8'h6F;
      4'd2:  c = 8'h6E;
      4'd3:  c = 8'h74;
      4'd4:  c = 8'h65;
      4'd5:  c = 8'h6E;
      4'd6:  c = 8'h74;
      4'd7:  c = 8'h2D;
      4'd8:  c = 8'h4C;
      4'd9:  c = 8'h65;
      4'd10: c = 8'h6E;
      4'd11: c = 8'h67;
      4'd12: c = 8'h74;
      4'd13: c = 8'h68;
      4'd14: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/http_response_header_parser.sv
// http_response_header_parser: top level, input register, result register and handshake
// depends on hrhp_pkg and hrhp_core
//
//   channel  direction  handshake                  payload
//   byte     in         byte_valid / byte_stall    byte_item   (byte_item_t)
//   result   out        result_valid / result_stall result_item (result_item_t)
//
// one byte per cycle unless a stalled result register holds the flow; each byte's result is registered
// the parser state update is one combinational pass between the input and result registers
// rst clears the parser state and both pipeline registers
// byte_stall rises only when the input register is full and the result register is stalled
`default_nettype none

module http_response_header_parser import hrhp_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   byte_valid,
  output logic        byte_stall,
  input  wire byte_item_t byte_item,
  output logic        result_valid,
  input  wire logic   result_stall,
  output result_item_t result_item
);

  logic         in_full;
  byte_item_t   in_item;
  logic         advance;
  logic         step;
  result_item_t core_result;

  // result register can take a new item
  assign advance    = !(result_valid && result_stall);
  assign step       = in_full && advance;
  assign byte_stall = in_full && !advance;

  hrhp_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid)
      in_item <= byte_item;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step)
      result_item <= core_result;
  end

`ifndef SYNTHESIS
  // parse state is never the unused code
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.parse_state == PS_MORE_DATA ||
      result_item.parse_state == PS_INVALID || result_item.parse_state == PS_COMPLETE)
    else $error("parse_state holds an unused code");

  // invalid responses carry no status and no body
  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.parse_state == PS_INVALID |->
      result_item.status_code == 10'd0 && !result_item.body_valid)
    else $error("invalid result carries status or body");

  // body byte is zero outside the body
  a_body_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.body_valid |-> result_item.body_byte == 8'h00)
    else $error("body_byte nonzero without body_valid");

  // a reported status lies in the accepted range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status_code != 10'd0 |->
      result_item.status_code >= 10'd100 && result_item.status_code <= 10'd599)
    else $error("status_code outside 100..599");

  // input side stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall && in_full)
    else $error("byte_stall without a stalled result");
`endif

endmodule

`default_nettype wire

>>> src/hrhp_core.sv
// hrhp_core: parser state registers and the per-byte next-state and result logic
// depends on hrhp_pkg
`default_nettype none

module hrhp_core import hrhp_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire byte_item_t   item,
  output result_item_t      result
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef enum logic [1:0] {VP_IDLE, VP_SKIP, VP_DIGITS, VP_SPARE} value_phase_t;
  typedef enum logic [1:0] {CR_NONE, CR_ONE, CR_LF_ONE, CR_TWO} crlf_t;

  // state registers
  logic [3:0]              byte_position;
  logic                    version_ok;
  logic signed [15:0]      status_value;
  logic                    invalid_flag;
  crlf_t                   crlf_run;
  logic [3:0]              match_index;
  value_phase_t            value_phase;
  logic                    length_negative;
  logic [31:0]             declared_length;
  logic                    in_body;
  logic [COUNT_WIDTH-1:0]  body_count;

  // next values
  logic [3:0]              byte_position_next;
  logic                    version_ok_next;
  logic signed [15:0]      status_value_next;
  logic                    invalid_flag_next;
  crlf_t                   crlf_run_next;
  logic [3:0]              match_index_next;
  value_phase_t            value_phase_next;
  logic                    length_negative_next;
  logic [31:0]             declared_length_next;
  logic                    in_body_next;
  logic [COUNT_WIDTH-1:0]  body_count_next;

  // current state, with the start-of-response clear applied
  logic [3:0]              cur_pos;
  logic                    cur_ver;
  logic signed [15:0]      cur_status;
  logic                    cur_invalid;
  crlf_t                   cur_crlf;
  logic [3:0]              cur_match;
  value_phase_t            cur_phase;
  logic                    cur_neg;
  logic [31:0]             cur_len;
  logic                    cur_body;
  logic [COUNT_WIDTH-1:0]  cur_count;

  logic [7:0]              b;
  logic                    is_digit;
  logic [35:0]             len_times_ten;
  logic [31:0]             len_with_digit;
  logic [CMP_W-1:0]        count_cmp;
  logic [CMP_W-1:0]        len_cmp;
  logic                    length_positive;
  logic                    body_now;

  assign b        = item.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // clear before the byte when a new response starts
  always_comb begin
    if (item.new_message) begin
      cur_pos     = '0;
      cur_ver     = 1'b1;
      cur_status  = '0;
      cur_invalid = 1'b0;
      cur_crlf    = CR_NONE;
      cur_match   = '0;
      cur_phase   = VP_IDLE;
      cur_neg     = 1'b0;
      cur_len     = LENGTH_NONE;
      cur_body    = 1'b0;
      cur_count   = '0;
    end else begin
      cur_pos     = byte_position;
      cur_ver     = version_ok;
      cur_status  = status_value;
      cur_invalid = invalid_flag;
      cur_crlf    = crlf_run;
      cur_match   = match_index;
      cur_phase   = value_phase;
      cur_neg     = length_negative;
      cur_len     = declared_length;
      cur_body    = in_body;
      cur_count   = body_count;
    end
  end

  // length digit accumulate, saturating at the largest positive length
  assign len_times_ten = ({4'b0, cur_len} << 3) + ({4'b0, cur_len} << 1)
                       + {28'b0, b - CH_ZERO};
  assign len_with_digit = (len_times_ten > {4'b0, LENGTH_MAX}) ? LENGTH_MAX
                                                               : len_times_ten[31:0];

  // next-state logic for one byte
  always_comb begin
    byte_position_next   = cur_pos;
    version_ok_next      = cur_ver;
    status_value_next    = cur_status;
    invalid_flag_next    = cur_invalid;
    crlf_run_next        = cur_crlf;
    match_index_next     = cur_match;
    value_phase_next     = cur_phase;
    length_negative_next = cur_neg;
    declared_length_next = cur_len;
    in_body_next         = cur_body;
    body_count_next      = cur_count;
    body_now             = 1'b0;

    // status line: version text, version digit and three status characters
    if (cur_pos < POS_HEADER_DONE) begin
      if (cur_pos < POS_VERSION_DIGIT && b != version_char(cur_pos[2:0]))
        version_ok_next = 1'b0;
      if (cur_pos == POS_VERSION_DIGIT && b != CH_ZERO && b != CH_ONE)
        version_ok_next = 1'b0;
      if (cur_pos >= POS_STATUS_FIRST)
        status_value_next = cur_status * 16'sd10 + $signed({8'b0, b})
                          - $signed({8'b0, CH_ZERO});
      if (cur_pos == POS_STATUS_LAST && (!version_ok_next ||
          status_value_next < STATUS_MIN || status_value_next > STATUS_MAX))
        invalid_flag_next = 1'b1;
      byte_position_next = cur_pos + 4'd1;
    end

    if (cur_body) begin
      // body byte, saturating count
      body_now = 1'b1;
      if (cur_count != {COUNT_WIDTH{1'b1}})
        body_count_next = cur_count + 1'b1;
    end else begin
      // length value parse
      case (cur_phase)
        VP_SKIP: begin
          if (b == CH_SPACE || b == CH_TAB) begin
            value_phase_next = VP_SKIP;
          end else if (b == CH_PLUS) begin
            value_phase_next = VP_DIGITS;
          end else if (b == CH_MINUS) begin
            length_negative_next = 1'b1;
            value_phase_next     = VP_DIGITS;
          end else if (is_digit) begin
            declared_length_next = len_with_digit;
            value_phase_next     = VP_DIGITS;
          end else begin
            value_phase_next = VP_IDLE;
          end
        end
        VP_DIGITS: begin
          if (is_digit)
            declared_length_next = len_with_digit;
          else
            value_phase_next = VP_IDLE;
        end
        default: begin
          value_phase_next = cur_phase;
        end
      endcase

      // header name match at line starts
      if (cur_match != 4'd0 && cur_match < PAT_LEN) begin
        if (b == length_char(cur_match)) begin
          if (cur_match + 4'd1 == PAT_LEN) begin
            match_index_next     = 4'd0;
            value_phase_next     = VP_SKIP;
            declared_length_next = '0;
            length_negative_next = 1'b0;
          end else begin
            match_index_next = cur_match + 4'd1;
          end
        end else begin
          match_index_next = 4'd0;
        end
      end else begin
        match_index_next = (cur_crlf == CR_LF_ONE && b == length_char(4'd0)) ? 4'd1 : 4'd0;
      end

      // blank line search
      if (b == CH_CR) begin
        if (cur_crlf == CR_LF_ONE)
          crlf_run_next = CR_TWO;
        else
          crlf_run_next = CR_ONE;
      end else if (b == CH_LF) begin
        if (cur_crlf == CR_ONE) begin
          crlf_run_next = CR_LF_ONE;
        end else if (cur_crlf == CR_TWO) begin
          crlf_run_next = CR_NONE;
          in_body_next  = 1'b1;
        end else begin
          crlf_run_next = CR_NONE;
        end
      end else begin
        crlf_run_next = CR_NONE;
      end
    end
  end

  // result for this byte
  assign count_cmp       = CMP_W'(body_count_next);
  assign len_cmp         = CMP_W'(declared_length_next);
  assign length_positive = !length_negative_next && declared_length_next != LENGTH_NONE
                        && declared_length_next != 32'd0;

  always_comb begin
    result = '0;
    if (byte_position_next >= POS_HEADER_DONE) begin
      if (invalid_flag_next) begin
        result.parse_state = PS_INVALID;
      end else begin
        result.status_code = status_value_next[9:0];
        result.body_valid  = body_now;
        result.body_byte   = body_now ? b : 8'h00;
        if (in_body_next && length_positive && count_cmp == len_cmp)
          result.parse_state = PS_COMPLETE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      version_ok      <= 1'b1;
      status_value    <= '0;
      invalid_flag    <= 1'b0;
      crlf_run        <= CR_NONE;
      match_index     <= '0;
      value_phase     <= VP_IDLE;
      length_negative <= 1'b0;
      declared_length <= LENGTH_NONE;
      in_body         <= 1'b0;
      body_count      <= '0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      version_ok      <= version_ok_next;
      status_value    <= status_value_next;
      invalid_flag    <= invalid_flag_next;
      crlf_run        <= crlf_run_next;
      match_index     <= match_index_next;
      value_phase     <= value_phase_next;
      length_negative <= length_negative_next;
      declared_length <= declared_length_next;
      in_body         <= in_body_next;
      body_count      <= body_count_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_http_response_header_parser.sv
// tb_http_response_header_parser: self-checking testbench for the response header parser
// depends on hrhp_pkg and http_response_header_parser; a scoreboard class predicts each result
// directed status lines first, then random responses with random idle and stall on both sides

module tb_http_response_header_parser;
  import hrhp_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_BYTES   = 400;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES    = 40;
  localparam int PAUSE_AT_RESP  = 5;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 100000;
  localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;

  typedef enum int {VAL_IDLE, VAL_BLANKS, VAL_DIGITS} value_phase_t;

  // predicts one result per accepted item and checks the results in order
  class parse_scoreboard;
    int               byte_pos;
    bit               version_ok;
    int               status_value;
    bit               invalid_flag;
    int               crlf_run;
    int               match_idx;
    value_phase_t     value_phase;
    bit               length_neg;
    logic [31:0]      declared_len;
    bit               in_body;
    longint unsigned  body_count;
    result_item_t     expected_results[$];
    int               errors;
    int               completes;
    int               invalids;
    int               body_seen;
    string            version_text = "HTTP/1.";
    string            length_text = "Content-Length:";

    function new();
      clear_state();
    endfunction

    function void clear_state();
      byte_pos     = 0;
      version_ok   = 1'b1;
      status_value = 0;
      invalid_flag = 1'b0;
      crlf_run     = 0;
      match_idx    = 0;
      value_phase  = VAL_IDLE;
      length_neg   = 1'b0;
      declared_len = LENGTH_NONE;
      in_body      = 1'b0;
      body_count   = 0;
    endfunction

    // decimal accumulate, saturating at the largest positive length
    function void add_digit(logic [7:0] b);
      longint unsigned v;
      v = 64'(declared_len) * 10 + 64'(b - CH_ZERO);
      declared_len = (v > 64'(LENGTH_MAX)) ? LENGTH_MAX : v[31:0];
    endfunction

    function void note_byte(byte_item_t it);
      logic [7:0]   b;
      int           prev;
      bit           digit;
      bit           body_now;
      result_item_t r;
      b = it.data_byte;
      body_now = 1'b0;
      r = '0;
      if (it.new_message) clear_state();

      // status line: version text, version digit, three status characters
      if (byte_pos < POS_HEADER_DONE) begin
        if (byte_pos < POS_VERSION_DIGIT && b != version_text[byte_pos]) version_ok = 1'b0;
        if (byte_pos == POS_VERSION_DIGIT && b != CH_ZERO && b != CH_ONE) version_ok = 1'b0;
        if (byte_pos >= POS_STATUS_FIRST)
          status_value = status_value * 10 + int'(b) - int'(CH_ZERO);
        if (byte_pos == POS_STATUS_LAST &&
            (!version_ok || status_value < STATUS_MIN || status_value > STATUS_MAX))
          invalid_flag = 1'b1;
        byte_pos++;
      end

      if (in_body) begin
        body_now = 1'b1;
        if (body_count < COUNT_MAX) body_count++;
      end else begin
        prev = crlf_run;
        digit = (b >= CH_ZERO && b <= CH_NINE);

        // length value after the colon
        if (value_phase == VAL_BLANKS) begin
          if (b == CH_SPACE || b == CH_TAB) begin
            // still skipping blanks
          end else if (b == CH_PLUS) begin
            value_phase = VAL_DIGITS;
          end else if (b == CH_MINUS) begin
            length_neg = 1'b1;
            value_phase = VAL_DIGITS;
          end else if (digit) begin
            add_digit(b);
            value_phase = VAL_DIGITS;
          end else begin
            value_phase = VAL_IDLE;
          end
        end else if (value_phase == VAL_DIGITS) begin
          if (digit) add_digit(b);
          else value_phase = VAL_IDLE;
        end

        // header name match, only at the start of a line
        if (match_idx > 0 && match_idx < PAT_LEN) begin
          if (b == length_text[match_idx]) begin
            match_idx++;
            if (match_idx == PAT_LEN) begin
              match_idx = 0;
              value_phase = VAL_BLANKS;
              declared_len = 0;
              length_neg = 1'b0;
            end
          end else begin
            match_idx = 0;
          end
        end else begin
          match_idx = (prev == 2 && b == length_text[0]) ? 1 : 0;
        end

        // blank line detection
        if (b == CH_CR) begin
          crlf_run = (prev == 2) ? 3 : 1;
        end else if (b == CH_LF) begin
          if (prev == 1) begin
            crlf_run = 2;
          end else if (prev == 3) begin
            crlf_run = 0;
            in_body = 1'b1;
          end else begin
            crlf_run = 0;
          end
        end else begin
          crlf_run = 0;
        end
      end

      // result fields
      if (byte_pos >= POS_HEADER_DONE) begin
        if (invalid_flag) begin
          r.parse_state = PS_INVALID;
          body_now = 1'b0;
        end else begin
          r.status_code = status_value[9:0];
          if (in_body && !length_neg && declared_len != LENGTH_NONE && declared_len > 0 &&
              body_count == 64'(declared_len))
            r.parse_state = PS_COMPLETE;
          else
            r.parse_state = PS_MORE_DATA;
        end
      end else begin
        body_now = 1'b0;
      end
      r.body_valid = body_now;
      r.body_byte = body_now ? b : 8'h00;
      expected_results.push_back(r);
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_result(result_item_t got);
      result_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual state %0d status %0d body %0b/%0d",
                 $time, got.parse_state, got.status_code, got.body_valid, got.body_byte);
        return;
      end
      want = expected_results.pop_front();
      if (got.parse_state == PS_COMPLETE) completes++;
      if (got.parse_state == PS_INVALID) invalids++;
      if (got.body_valid) body_seen++;
      if (got.parse_state !== want.parse_state)
        report_field("parse_state", want.parse_state, got.parse_state);
      if (got.status_code !== want.status_code)
        report_field("status_code", want.status_code, got.status_code);
      if (got.body_valid !== want.body_valid)
        report_field("body_valid", want.body_valid, got.body_valid);
      if (got.body_byte !== want.body_byte)
        report_field("body_byte", want.body_byte, got.body_byte);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_item_t   byte_item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  parse_scoreboard sb = new();
  logic [7:0]      msg_bytes[$];
  bit              steady;
  int              sent_bytes;
  int              responses;
  int              results_taken;
  int              cycles;

  http_response_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycles, sb.outstanding());
      $display("tb_http_response_header_parser: FAIL");
      $finish;
    end
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void push_crlf();
    msg_bytes.push_back(CH_CR);
    msg_bytes.push_back(CH_LF);
  endfunction

  // status line, a few header lines, blank line, body
  function automatic void build_response();
    int len_value;
    int sign;
    int digits;
    int body_len;
    msg_bytes.delete();
    push_text("HTTP/1.");
    if ($urandom_range(0, 9) != 0) msg_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    else msg_bytes.push_back(8'($urandom));
    msg_bytes.push_back(($urandom_range(0, 7) != 0) ? CH_SPACE : 8'($urandom));
    case ($urandom_range(0, 9))
      0: repeat (3) msg_bytes.push_back(8'($urandom));
      1: push_text($sformatf("%03d", $urandom_range(0, 999)));
      default: push_text($sformatf("%0d", $urandom_range(100, 599)));
    endcase
    push_crlf();
    len_value = 0;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: begin
          push_text($sformatf("X-Tag: %0d", $urandom_range(0, 99)));
          push_crlf();
        end
        1: begin
          // near miss on the last name character, unless the random character happens to be 'h'
          push_text("Content-Lengt");
          msg_bytes.push_back(8'($urandom_range(33, 126)));
          push_text(": 3");
          push_crlf();
        end
        2: begin
          push_text("content-length: 2");
          push_crlf();
        end
        default: begin
          push_text("Content-Length:");
          repeat ($urandom_range(0, 2)) msg_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          sign = $urandom_range(0, 9);
          if (sign == 0) msg_bytes.push_back(CH_MINUS);
          else if (sign == 1) msg_bytes.push_back(CH_PLUS);
          digits = $urandom_range(0, 7);
          if (digits == 0) begin
            len_value = 0;
          end else if (digits == 1) begin
            push_text("98765432109");
            len_value = 0;
          end else begin
            len_value = $urandom_range(0, 12);
            push_text($sformatf("%0d", len_value));
          end
          if (sign == 0) len_value = 0;
          if ($urandom_range(0, 5) == 0) push_text(" x");
          push_crlf();
        end
      endcase
    end
    push_crlf();
    body_len = (len_value > 0 && $urandom_range(0, 2) != 0) ? len_value : $urandom_range(0, 8);
    repeat (body_len) msg_bytes.push_back(8'($urandom));
  endfunction

  // one item through the byte channel, driven at the falling edge
  task automatic send_item(input logic [7:0] b, input bit fresh);
    byte_item_t it;
    int         gap;
    it.data_byte = b;
    it.new_message = fresh;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(it);
    sent_bytes++;
  endtask

  // first item may start a fresh response; rarely a restart mid-response
  task automatic send_message(input bit fresh);
    for (int i = 0; i < msg_bytes.size(); i++)
      send_item(msg_bytes[i], (i == 0) ? fresh : ($urandom_range(0, 199) == 0));
    responses++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // result side: random stall per item, one long hold to back up the pipeline
  initial begin : result_side
    int gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (results_taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      @(negedge clk);
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result_item);
      results_taken++;
    end
  end

  initial begin : byte_side
    int kind;
    int keep;
    int directed_bytes;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: highest valid status on version 1.0, then a bad version and low status
    // followed by extreme bytes while invalid sticks
    steady = 1'b0;
    msg_bytes.delete();
    push_text("HTTP/1.0 599");
    send_message(1'b1);
    msg_bytes.delete();
    push_text("XTTP/1.2 099");
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    send_message(1'b1);
    directed_bytes = sent_bytes;

    // random responses: mostly well formed, some cut short, some noise
    while (sent_bytes < directed_bytes + RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_response();
      end else if (kind < 85) begin
        build_response();
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end else begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 20))
          msg_bytes.push_back(($urandom_range(0, 3) == 0) ?
                              ($urandom_range(0, 1) ? CH_CR : CH_LF) : 8'($urandom));
      end
      send_message($urandom_range(0, 9) != 0);
      if (responses == PAUSE_AT_RESP) pause_until_drained();
    end

    steady = 1'b0;
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d responses in %0d bytes, %0d results checked",
             responses, sent_bytes, results_taken);
    $display("results seen: %0d complete, %0d invalid, %0d body bytes",
             sb.completes, sb.invalids, sb.body_seen);
    if (sb.errors == 0) begin
      $display("tb_http_response_header_parser: PASS");
    end else begin
      $display("tb_http_response_header_parser: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/hrhp_pkg.sv
src/hrhp_core.sv
src/http_response_header_parser.sv
tb/tb_http_response_header_parser.sv
